### src/rbm_pkg.sv
// shared types and constants for the rotated box mask combine unit
package rbm_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int LEVEL_BITS_DEF = 16;

	// fixed register widths
	localparam int CENTER_W   = 17;
	localparam int HALF_W     = 16;
	localparam int TRIG_W     = 16;
	localparam int FRAC_BITS  = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam logic [TRIG_W-1:0] COS_RESET = 16'h7fff;

	typedef enum logic [1:0] {
		MODE_ADD,
		MODE_SUB,
		MODE_MUL,
		MODE_NOT
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_HALF_W,
		REG_HALF_H,
		REG_COS,
		REG_SIN,
		REG_MODE
	} reg_idx_t;

	typedef struct packed {
		logic [CENTER_W-1:0] center_x;
		logic [CENTER_W-1:0] center_y;
		logic [HALF_W-1:0]   half_w;
		logic [HALF_W-1:0]   half_h;
		logic [TRIG_W-1:0]   cos_rot;
		logic [TRIG_W-1:0]   sin_rot;
		mode_t               mode;
	} cfg_t;

	typedef struct packed {
		logic s1;
		logic s2;
	} pipe_en_t;

endpackage

### src/rbm_cfg.sv
// configuration register file
module rbm_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [rbm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rbm_pkg::CFG_DATA_W-1:0]  cfg_data,
	output rbm_pkg::cfg_t                   cfg
);
	import rbm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x <= '0;
			cfg_q.center_y <= '0;
			cfg_q.half_w   <= '0;
			cfg_q.half_h   <= '0;
			cfg_q.cos_rot  <= COS_RESET;
			cfg_q.sin_rot  <= '0;
			cfg_q.mode     <= MODE_ADD;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CENTER_X: cfg_q.center_x <= cfg_data[CENTER_W-1:0];
				REG_CENTER_Y: cfg_q.center_y <= cfg_data[CENTER_W-1:0];
				REG_HALF_W:   cfg_q.half_w   <= cfg_data[HALF_W-1:0];
				REG_HALF_H:   cfg_q.half_h   <= cfg_data[HALF_W-1:0];
				REG_COS:      cfg_q.cos_rot  <= cfg_data[TRIG_W-1:0];
				REG_SIN:      cfg_q.sin_rot  <= cfg_data[TRIG_W-1:0];
				REG_MODE:     cfg_q.mode     <= mode_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### src/rbm_geom.sv
// center offset, rotation products and strict inside test
module rbm_geom #(
	parameter int COORD_BITS = rbm_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  rbm_pkg::pipe_en_t     en,
	input  logic [COORD_BITS-1:0] pixel_x,
	input  logic [COORD_BITS-1:0] pixel_y,
	input  rbm_pkg::cfg_t         cfg,
	output logic                  in_box
);
	import rbm_pkg::*;

	localparam int PX_W  = COORD_BITS + FRAC_BITS;
	localparam int DW    = ((PX_W + 1 > CENTER_W) ? PX_W + 1 : CENTER_W) + 1;
	localparam int PW    = DW + TRIG_W;
	localparam int LIM_W = HALF_W + TRIG_W - 1;
	localparam int RW    = ((PW + 1 > LIM_W + 1) ? PW + 1 : LIM_W + 1);

	logic signed [DW-1:0] dx_s1;
	logic signed [DW-1:0] dy_s1;
	logic signed [PW-1:0] pcx_s2;
	logic signed [PW-1:0] psy_s2;
	logic signed [PW-1:0] pcy_s2;
	logic signed [PW-1:0] psx_s2;

	logic signed [RW-1:0] rx;
	logic signed [RW-1:0] ry;
	logic signed [RW-1:0] lim_w;
	logic signed [RW-1:0] lim_h;

	// pixel to q.4 and offset from center
	always_ff @(posedge clk) begin
		if (en.s1) begin
			dx_s1 <= DW'($signed({1'b0, pixel_x, FRAC_BITS'(0)})) - DW'($signed(cfg.center_x));
			dy_s1 <= DW'($signed({1'b0, pixel_y, FRAC_BITS'(0)})) - DW'($signed(cfg.center_y));
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			pcx_s2 <= PW'($signed(cfg.cos_rot)) * PW'(dx_s1);
			psy_s2 <= PW'($signed(cfg.sin_rot)) * PW'(dy_s1);
			pcy_s2 <= PW'($signed(cfg.cos_rot)) * PW'(dy_s1);
			psx_s2 <= PW'($signed(cfg.sin_rot)) * PW'(dx_s1);
		end
	end

	always_comb begin
		rx    = RW'(pcx_s2) + RW'(psy_s2);
		ry    = RW'(pcy_s2) - RW'(psx_s2);
		// half sizes scaled up to match the products with the q1.15 trig values
		lim_w = $signed(RW'({cfg.half_w, (TRIG_W - 1)'(0)}));
		lim_h = $signed(RW'({cfg.half_h, (TRIG_W - 1)'(0)}));
		in_box = (rx > -lim_w) && (rx < lim_w) && (ry > -lim_h) && (ry < lim_h);
	end

endmodule

### src/rbm_level.sv
// level path: product, rounded unorm divide and mode combine
module rbm_level #(
	parameter int LEVEL_BITS = rbm_pkg::LEVEL_BITS_DEF
) (
	input  logic                  clk,
	input  rbm_pkg::pipe_en_t     en,
	input  logic [LEVEL_BITS-1:0] mask_level,
	input  logic [LEVEL_BITS-1:0] value_level,
	input  logic                  in_box,
	input  rbm_pkg::mode_t        mode,
	output logic [LEVEL_BITS-1:0] level_nx
);
	import rbm_pkg::*;

	localparam int XW = 2 * LEVEL_BITS + 1;
	localparam logic [XW-1:0] RND = XW'((1 << (LEVEL_BITS - 1)) - 1);
	localparam logic [XW-1:0] ONE = XW'(1);

	logic [LEVEL_BITS-1:0]   m_s1;
	logic [LEVEL_BITS-1:0]   v_s1;
	logic [LEVEL_BITS-1:0]   m_s2;
	logic [LEVEL_BITS-1:0]   v_s2;
	logic [2*LEVEL_BITS-1:0] prod_s2;

	logic [XW-1:0]         xr;
	logic [XW-1:0]         qsum;
	logic [LEVEL_BITS-1:0] mul_lvl;
	logic [LEVEL_BITS-1:0] max_lvl;
	logic [LEVEL_BITS-1:0] sub_lvl;
	logic [LEVEL_BITS-1:0] not_lvl;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			m_s1 <= mask_level;
			v_s1 <= value_level;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			m_s2    <= m_s1;
			v_s2    <= v_s1;
			prod_s2 <= m_s1 * v_s1;
		end
	end

	always_comb begin
		// divide by 2^n-1: (x + (x >> n) + 1) >> n, exact below (2^n-1)^2 + 2^n
		xr      = XW'(prod_s2) + RND;
		qsum    = xr + (xr >> LEVEL_BITS) + ONE;
		mul_lvl = qsum[2*LEVEL_BITS-1:LEVEL_BITS];
		max_lvl = (m_s2 > v_s2) ? m_s2 : v_s2;
		sub_lvl = (m_s2 > v_s2) ? (m_s2 - v_s2) : '0;
		not_lvl = (m_s2 != '0) ? '0 : v_s2;
		unique case (mode)
			MODE_ADD: level_nx = in_box ? max_lvl : m_s2;
			MODE_SUB: level_nx = in_box ? sub_lvl : m_s2;
			MODE_MUL: level_nx = in_box ? mul_lvl : '0;
			MODE_NOT: level_nx = in_box ? not_lvl : m_s2;
		endcase
	end

endmodule

### src/rotated_box_mask_combine_unit.sv
// Rotated box mask combiner: one pixel item per clock while in_stall is low; an item's result
// is presented once the item has passed through all three register stages.
// The three register stages are the input offset stage, the rotation and level product stage,
// and the result register; a stalled result lets the two earlier stages keep filling, and
// in_stall rises only once all three hold items. The configuration port is always ready;
// registers are meant to be written while no item is in flight.
module rotated_box_mask_combine_unit #(
	parameter int COORD_BITS = rbm_pkg::COORD_BITS_DEF,
	parameter int LEVEL_BITS = rbm_pkg::LEVEL_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rbm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rbm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [COORD_BITS-1:0]          pixel_x,
	input  logic [COORD_BITS-1:0]          pixel_y,
	input  logic [LEVEL_BITS-1:0]          mask_level,
	input  logic [LEVEL_BITS-1:0]          value_level,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [LEVEL_BITS-1:0]          level_out,
	output logic                           is_inside
);
	import rbm_pkg::*;

	cfg_t     cfg;
	pipe_en_t en;

	logic vld_s1;
	logic vld_s2;
	logic vld_s3;
	logic load1;
	logic load2;
	logic load3;
	logic en3;
	logic in_box;

	logic [LEVEL_BITS-1:0] level_nx;
	logic [LEVEL_BITS-1:0] level_s3;
	logic                  inside_s3;

	assign cfg_ready = 1'b1;

	rbm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// a stage loads when it is empty or the one after it loads
	assign load3    = !vld_s3 || !out_stall;
	assign load2    = !vld_s2 || load3;
	assign load1    = !vld_s1 || load2;
	assign in_stall = !load1;
	assign en.s1    = load1 && in_valid;
	assign en.s2    = load2 && vld_s1;
	assign en3      = load3 && vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (load1) begin
				vld_s1 <= in_valid;
			end
			if (load2) begin
				vld_s2 <= vld_s1;
			end
			if (load3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	rbm_geom #(
		.COORD_BITS (COORD_BITS)
	) u_geom (
		.clk     (clk),
		.en      (en),
		.pixel_x (pixel_x),
		.pixel_y (pixel_y),
		.cfg     (cfg),
		.in_box  (in_box)
	);

	rbm_level #(
		.LEVEL_BITS (LEVEL_BITS)
	) u_level (
		.clk         (clk),
		.en          (en),
		.mask_level  (mask_level),
		.value_level (value_level),
		.in_box      (in_box),
		.mode        (cfg.mode),
		.level_nx    (level_nx)
	);

	always_ff @(posedge clk) begin
		if (en3) begin
			level_s3  <= level_nx;
			inside_s3 <= in_box;
		end
	end

	assign out_valid = vld_s3;
	assign level_out = level_s3;
	assign is_inside = inside_s3;

`ifndef SYNTHESIS
	// input only backs up when every stage holds an item
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld_s1 && vld_s2 && vld_s3 && out_stall))
		else $error("input stalled with room in the pipeline");

	// a zero half width is an empty box
	a_empty_box: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && cfg.half_w == '0) |-> !is_inside)
		else $error("pixel inside a box of zero width");

	// multiply mode clears everything outside the box
	a_mul_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && cfg.mode == MODE_MUL && !is_inside) |-> (level_out == '0))
		else $error("multiply mode left a level outside the box");
`endif

endmodule

### test/rotated_box_mask_combine_unit_test.sv
// self-checking testbench for the rotated box mask combine unit
`timescale 1ns / 1ps

module rotated_box_mask_combine_unit_test;
	import rbm_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int LB = LEVEL_BITS_DEF;
	localparam int CRD_MAX = (1 << CB) - 1;
	localparam longint LVL_MAX = (longint'(1) << LB) - 1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int RESET_CYCLES = 11;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 50;
	localparam int LONG_HOLD = 120;
	localparam int DRAIN_CYCLES = 10;

	typedef struct packed {
		logic [CB-1:0] x;
		logic [CB-1:0] y;
		logic [LB-1:0] m;
		logic [LB-1:0] v;
	} pixel_t;

	typedef struct packed {
		logic [LB-1:0] level;
		logic          in_box;
	} level_result_t;

	typedef struct {
		bit                    is_reg;
		logic [CFG_IDX_W-1:0]  reg_index;
		logic [CFG_DATA_W-1:0] reg_data;
		pixel_t                px;
		bit                    typed;
		level_result_t         want;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [CB-1:0]         pixel_x = '0;
	logic [CB-1:0]         pixel_y = '0;
	logic [LB-1:0]         mask_level = '0;
	logic [LB-1:0]         value_level = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [LB-1:0]         level_out;
	logic                  is_inside;

	// typed expectation travels with the item it belongs to
	bit            row_typed = 1'b0;
	level_result_t row_want = '0;

	cfg_t          box_cfg;
	level_result_t expected_levels[$];
	stim_row_t     stim_rows[$];
	int            pixels_sent = 0;
	int            results_seen = 0;
	int            err_count = 0;
	int            send_idle_pct = 0;
	int            recv_idle_pct = 0;
	bit            offering = 1'b0;
	bit            cfg_on = 1'b0;
	bit            hold_token = 1'b0;
	bit            hold_seen = 1'b0;
	int            hold_left = 0;

	rotated_box_mask_combine_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.mask_level(mask_level),
		.value_level(value_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.level_out(level_out),
		.is_inside(is_inside)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("FAIL rotated_box_mask_combine_unit");
		$finish;
	end

	function automatic level_result_t predict_box_level(input cfg_t c, input pixel_t p);
		level_result_t r;
		longint dx, dy, cr, sr, rx, ry, hw, hh, q;
		dx = longint'({p.x, 4'b0000}) - longint'($signed(c.center_x));
		dy = longint'({p.y, 4'b0000}) - longint'($signed(c.center_y));
		cr = longint'($signed(c.cos_rot));
		sr = longint'($signed(c.sin_rot));
		rx = cr * dx + sr * dy;
		ry = cr * dy - sr * dx;
		hw = longint'(c.half_w) * 32768;
		hh = longint'(c.half_h) * 32768;
		// open box: a pixel on the edge is outside, and a zero half size is empty
		r.in_box = (rx > -hw) && (rx < hw) && (ry > -hh) && (ry < hh);
		case (c.mode)
			MODE_ADD: r.level = !r.in_box ? p.m : ((p.m > p.v) ? p.m : p.v);
			MODE_SUB: r.level = !r.in_box ? p.m : ((p.m > p.v) ? p.m - p.v : '0);
			MODE_MUL: begin
				q = (longint'(p.m) * longint'(p.v) + LVL_MAX / 2) / LVL_MAX;
				r.level = r.in_box ? q[LB-1:0] : '0;
			end
			MODE_NOT: r.level = !r.in_box ? p.m : ((p.m != '0) ? '0 : p.v);
		endcase
		return r;
	endfunction

	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_CENTER_X: box_cfg.center_x = d;
			REG_CENTER_Y: box_cfg.center_y = d;
			REG_HALF_W:   box_cfg.half_w = d[HALF_W-1:0];
			REG_HALF_H:   box_cfg.half_h = d[HALF_W-1:0];
			REG_COS:      box_cfg.cos_rot = d[TRIG_W-1:0];
			REG_SIN:      box_cfg.sin_rot = d[TRIG_W-1:0];
			REG_MODE:     box_cfg.mode = mode_t'(d[1:0]);
			default: ;
		endcase
	endtask

	task automatic flag_error(input string msg);
		err_count++;
		if (err_count <= 10)
			$display("mismatch: %s", msg);
	endtask

	always @(posedge clk) begin : score
		level_result_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				if (row_typed)
					want = row_want;
				else
					want = predict_box_level(box_cfg,
						'{pixel_x, pixel_y, mask_level, value_level});
				expected_levels.push_back(want);
			end
			if (out_valid && !out_stall) begin
				if (expected_levels.size() == 0) begin
					flag_error($sformatf("result with none expected: level %0h inside %0d",
						level_out, is_inside));
				end else begin
					want = expected_levels.pop_front();
					if (level_out !== want.level)
						flag_error($sformatf("level_out expected %0h, got %0h",
							want.level, level_out));
					if (is_inside !== want.in_box)
						flag_error($sformatf("is_inside expected %0d, got %0d",
							want.in_box, is_inside));
					results_seen++;
				end
			end
		end
	end

	// receiver stall, with a long hold-off on request
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic send_pixel(input pixel_t p, input bit typed, input level_result_t want);
		if (cfg_on) begin
			cfg_valid <= 1'b0;
			cfg_on = 1'b0;
		end
		while ($urandom_range(99) < send_idle_pct) begin
			if (offering) begin
				in_valid <= 1'b0;
				offering = 1'b0;
			end
			@(posedge clk);
		end
		in_valid <= 1'b1;
		offering = 1'b1;
		pixel_x <= p.x;
		pixel_y <= p.y;
		mask_level <= p.m;
		value_level <= p.v;
		row_typed <= typed;
		row_want <= want;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pixels_sent++;
	endtask

	task automatic wait_drain();
		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
		while (results_seen != pixels_sent)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		cfg_on = 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, data);
	endtask

	function automatic logic [CENTER_W-1:0] pick_center();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return 17'h10000;
		if (r < 20)
			return 17'h0ffff;
		if (r < 85)
			return CENTER_W'($urandom_range(0, 65535));
		return CENTER_W'($urandom_range(0, 17'h1ffff));
	endfunction

	function automatic logic [HALF_W-1:0] pick_half();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		if (r < 20)
			return 16'hffff;
		if (r < 70)
			return HALF_W'($urandom_range(16, 2048));
		return HALF_W'($urandom_range(0, 65535));
	endfunction

	function automatic logic [TRIG_W-1:0] pick_trig();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return 16'h8000;
		if (r < 30)
			return 16'h7fff;
		if (r < 40)
			return '0;
		return TRIG_W'($urandom_range(0, 65535));
	endfunction

	function automatic logic [LB-1:0] pick_level();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		if (r < 20)
			return '1;
		return LB'($urandom_range(0, 65535));
	endfunction

	// half the pixels land near the box so both sides of the edge get hit
	function automatic pixel_t random_pixel();
		pixel_t p;
		int span, cx, cy;
		p.m = pick_level();
		p.v = ($urandom_range(9) == 0) ? p.m : pick_level();
		if ($urandom_range(1) == 0) begin
			p.x = CB'($urandom_range(0, CRD_MAX));
			p.y = CB'($urandom_range(0, CRD_MAX));
		end else begin
			span = ((box_cfg.half_w > box_cfg.half_h) ? box_cfg.half_w : box_cfg.half_h);
			span = span / 16 + 2;
			cx = $signed(box_cfg.center_x);
			cy = $signed(box_cfg.center_y);
			cx = cx / 16 + int'($urandom_range(0, 2 * span)) - span;
			cy = cy / 16 + int'($urandom_range(0, 2 * span)) - span;
			cx = (cx < 0) ? 0 : ((cx > CRD_MAX) ? CRD_MAX : cx);
			cy = (cy < 0) ? 0 : ((cy > CRD_MAX) ? CRD_MAX : cy);
			p.x = cx[CB-1:0];
			p.y = cy[CB-1:0];
		end
		return p;
	endfunction

	task automatic randomize_box();
		write_reg(REG_CENTER_X, pick_center());
		write_reg(REG_CENTER_Y, pick_center());
		write_reg(REG_HALF_W, {1'($urandom_range(1)), pick_half()});
		write_reg(REG_HALF_H, {1'($urandom_range(1)), pick_half()});
		write_reg(REG_COS, {1'($urandom_range(1)), pick_trig()});
		write_reg(REG_SIN, {1'($urandom_range(1)), pick_trig()});
		write_reg(REG_MODE, CFG_DATA_W'($urandom_range(0, 17'h1ffff)));
		if ($urandom_range(4) == 0)
			write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 17'h1ffff)));
	endtask

	task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		stim_row_t row;
		row = '{1'b1, idx, d, '0, 1'b0, '0};
		stim_rows.push_back(row);
	endtask

	task automatic add_pixel(input int x, input int y, input int m, input int v);
		stim_row_t row;
		row = '{1'b0, '0, '0, '{CB'(x), CB'(y), LB'(m), LB'(v)}, 1'b0, '0};
		stim_rows.push_back(row);
	endtask

	task automatic add_checked(input int x, input int y, input int m, input int v,
			input int level, input bit in_box);
		stim_row_t row;
		row = '{1'b0, '0, '0, '{CB'(x), CB'(y), LB'(m), LB'(v)}, 1'b1,
			'{LB'(level), in_box}};
		stim_rows.push_back(row);
	endtask

	initial begin : run
		int phase, k;
		stim_row_t row;
		box_cfg.center_x = '0;
		box_cfg.center_y = '0;
		box_cfg.half_w = '0;
		box_cfg.half_h = '0;
		box_cfg.cos_rot = COS_RESET;
		box_cfg.sin_rot = '0;
		box_cfg.mode = MODE_ADD;

		// empty box after reset, add mode passes the mask through
		add_checked(0, 0, 16'h1234, 16'hffff, 16'h1234, 1'b0);
		add_checked(CRD_MAX, CRD_MAX, 16'hffff, 16'h0000, 16'hffff, 1'b0);
		add_reg(REG_HALF_W, 17'h0ffff);
		add_reg(REG_HALF_H, 17'h0ffff);
		add_checked(0, 0, 16'h0000, 16'hffff, 16'hffff, 1'b1);
		add_pixel(CRD_MAX, CRD_MAX, 16'ha5a5, 16'h5a5a);
		add_reg(REG_MODE, MODE_SUB);
		add_checked(0, 0, 16'h0000, 16'hffff, 16'h0000, 1'b1);
		add_pixel(10, 20, 16'h8000, 16'h7fff);
		add_pixel(5, 5, 16'h1234, 16'h1234);
		add_reg(REG_MODE, MODE_MUL);
		add_checked(0, 0, 16'hffff, 16'hffff, 16'hffff, 1'b1);
		add_checked(0, 0, 16'h0000, 16'hffff, 16'h0000, 1'b1);
		add_pixel(1, 1, 16'h8000, 16'h8000);
		add_reg(REG_MODE, MODE_NOT);
		add_checked(0, 0, 16'h0000, 16'hbeef, 16'hbeef, 1'b1);
		add_checked(0, 0, 16'h0001, 16'hbeef, 16'h0000, 1'b1);
		// centers at their extremes put the first pixel outside and leave the second just inside
		add_reg(REG_CENTER_X, 17'h10000);
		add_reg(REG_CENTER_Y, 17'h0ffff);
		add_pixel(CRD_MAX, 0, 16'hc3c3, 16'h1111);
		add_reg(REG_UNUSED, 17'h00000);
		add_pixel(0, CRD_MAX, 16'h0000, 16'hffff);
		// one pixel half width with cos at -1: the next pixel sits on the edge
		add_reg(REG_CENTER_X, 17'h00000);
		add_reg(REG_CENTER_Y, 17'h00000);
		add_reg(REG_HALF_W, 17'h00010);
		add_reg(REG_COS, 17'h08000);
		add_reg(REG_MODE, MODE_MUL);
		add_pixel(1, 0, 16'hffff, 16'hffff);
		add_pixel(0, 0, 16'hffff, 16'hffff);
		// quarter turn swaps the axes
		add_reg(REG_COS, 17'h00000);
		add_reg(REG_SIN, 17'h07fff);
		add_pixel(0, 1, 16'h4000, 16'hc000);
		add_pixel(3, 2, 16'h4000, 16'hc000);
		add_reg(REG_HALF_W, 17'h00000);
		add_checked(0, 0, 16'hffff, 16'hffff, 16'h0000, 1'b0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 17;
		recv_idle_pct = 66;

		foreach (stim_rows[i]) begin
			row = stim_rows[i];
			if (row.is_reg) begin
				wait_drain();
				write_reg(row.reg_index, row.reg_data);
			end else begin
				send_pixel(row.px, row.typed, row.want);
			end
		end

		for (phase = 0; phase < PHASES; phase++) begin
			if (phase == PHASES / 3) begin
				send_idle_pct = 66;
				recv_idle_pct = 17;
			end else if (phase == 2 * PHASES / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			wait_drain();
			randomize_box();
			// long receiver hold while the sender keeps pushing fills the pipe
			if (phase == PHASES - 2)
				hold_token <= ~hold_token;
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (phase == PHASES / 2 && k == PHASE_ITEMS / 2)
					wait_drain();
				send_pixel(random_pixel(), 1'b0, '0);
			end
		end

		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_levels.size() != 0)
			flag_error($sformatf("%0d results never arrived", expected_levels.size()));
		if (err_count == 0)
			$display("PASS rotated_box_mask_combine_unit");
		else
			$display("FAIL rotated_box_mask_combine_unit");
		$finish;
	end

endmodule

### sim.f
src/rbm_pkg.sv
src/rbm_cfg.sv
src/rbm_geom.sv
src/rbm_level.sv
src/rotated_box_mask_combine_unit.sv
test/rotated_box_mask_combine_unit_test.sv
